>>> rtl/indexed_word_list_defines.svh
// Assertion macros shared by the checking code of the indexed word list.
`ifndef INDEXED_WORD_LIST_DEFINES_SVH
`define INDEXED_WORD_LIST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IWL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iwl_pkg.sv
package iwl_pkg;

    localparam int WORD_W        = 32;
    localparam int IDX_W         = 8;
    localparam int SUM_W         = IDX_W + 1;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 64;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SWAP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word_in;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   word_out;
        logic [IDX_W-1:0]    count_out;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Read address source: a position, b position, idx+1, idx+2
    typedef enum logic [1:0] {
        RD_A     = 2'd0,
        RD_B     = 2'd1,
        RD_NEXT  = 2'd2,
        RD_AFTER = 2'd3
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE  = 3'd0,
        WR_FRONT = 3'd1,
        WR_BACK  = 3'd2,
        WR_A     = 3'd3,
        WR_B     = 3'd4,
        WR_IDX   = 3'd5
    } wr_sel_t;

    typedef enum logic [1:0] {
        WORD_ZERO  = 2'd0,
        WORD_RDATA = 2'd1,
        WORD_HOLD  = 2'd2
    } word_sel_t;

    typedef struct packed {
        logic                load_req;
        logic                rd_en;
        rd_sel_t             rd_sel;
        wr_sel_t             wr_sel;
        logic                hold_en;
        logic                idx_inc;
        logic                count_inc;
        logic                count_dec;
        logic                head_dec;
        logic                finish;
        logic [STATUS_W-1:0] fin_status;
        word_sel_t           fin_word;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             bad_a;
        logic             bad_b;
        logic             same_ab;
        logic             next_in;
        logic             after_in;
    } dp_status_t;

endpackage

>>> rtl/iwl_ram.sv
module iwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/iwl_datapath.sv
module iwl_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iwl_pkg::req_t         request,
    input  iwl_pkg::ctrl_cmd_t    ctl,
    output iwl_pkg::dp_status_t   st,
    output logic                  done,
    output iwl_pkg::rsp_t         result
);

    import iwl_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0]  DEPTH_CNT = IDX_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // Ring position: list position pos lives at (head + pos) mod DEPTH.
    function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                              input logic [IDX_W-1:0]  pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(pos);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    req_t              req_reg;
    logic [ADDR_W-1:0] head_reg,  head_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [WORD_W-1:0] hold_reg;
    rsp_t              result_reg;
    logic              done_reg;

    logic [ADDR_W-1:0] head_prev;
    logic [SUM_W-1:0]  idx_plus1, idx_plus2;
    logic [IDX_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [WORD_W-1:0] wr_data, rd_data, fin_word;
    logic              wr_en;

    assign head_prev = (head_reg == '0) ? LAST_ADDR : head_reg - 1'b1;
    assign idx_plus1 = SUM_W'(idx_reg) + SUM_W'(1);
    assign idx_plus2 = SUM_W'(idx_reg) + SUM_W'(2);

    // Status back to the controller
    assign st.cmd      = req_reg.cmd;
    assign st.full     = (count_reg >= DEPTH_CNT);
    assign st.bad_a    = (req_reg.first_index  >= count_reg);
    assign st.bad_b    = (req_reg.second_index >= count_reg);
    assign st.same_ab  = (req_reg.first_index == req_reg.second_index);
    assign st.next_in  = (idx_plus1 < SUM_W'(count_reg));
    assign st.after_in = (idx_plus2 < SUM_W'(count_reg));

    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_A:     rd_pos = req_reg.first_index;
            RD_B:     rd_pos = req_reg.second_index;
            RD_NEXT:  rd_pos = idx_plus1[IDX_W-1:0];
            RD_AFTER: rd_pos = idx_plus2[IDX_W-1:0];
            default:  rd_pos = req_reg.first_index;
        endcase
    end

    assign rd_addr = phys(head_reg, rd_pos);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = phys(head_reg, idx_reg);
        wr_data = rd_data;
        unique case (ctl.wr_sel)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_FRONT:
            begin
                wr_addr = head_prev;
                wr_data = req_reg.word_in;
            end
            WR_BACK:
            begin
                wr_addr = phys(head_reg, count_reg);
                wr_data = req_reg.word_in;
            end
            WR_A:
            begin
                wr_addr = phys(head_reg, req_reg.first_index);
            end
            WR_B:
            begin
                wr_addr = phys(head_reg, req_reg.second_index);
                wr_data = hold_reg;
            end
            WR_IDX:
            begin
                wr_addr = phys(head_reg, idx_reg);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    iwl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        priority if (ctl.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    assign head_next = ctl.head_dec ? head_prev : head_reg;

    always_comb
    begin
        unique case (ctl.fin_word)
            WORD_ZERO:  fin_word = '0;
            WORD_RDATA: fin_word = rd_data;
            WORD_HOLD:  fin_word = hold_reg;
            default:    fin_word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= ctl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            req_reg <= request;
            idx_reg <= request.first_index;
        end
        else if (ctl.idx_inc)
        begin
            idx_reg <= idx_plus1[IDX_W-1:0];
        end
        if (ctl.hold_en)
        begin
            hold_reg <= rd_data;
        end
        if (ctl.finish)
        begin
            result_reg.word_out  <= fin_word;
            result_reg.count_out <= count_next;
            result_reg.status    <= ctl.fin_status;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/iwl_ctrl.sv
module iwl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  iwl_pkg::dp_status_t  st,
    output logic                 busy,
    output iwl_pkg::ctrl_cmd_t   ctl
);

    import iwl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CHECK     = 8'b0000_0010,
        S_READ_WAIT = 8'b0000_0100,
        S_SWAP_B    = 8'b0000_1000,
        S_SWAP_WA   = 8'b0001_0000,
        S_SWAP_WB   = 8'b0010_0000,
        S_REM_GET   = 8'b0100_0000,
        S_REM_SHIFT = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        ctl            = '0;
        ctl.rd_sel     = RD_A;
        ctl.wr_sel     = WR_NONE;
        ctl.fin_status = ST_OK;
        ctl.fin_word   = WORD_ZERO;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                unique case (st.cmd)
                    CMD_ADD_FRONT, CMD_ADD_BACK:
                    begin
                        ctl.finish = 1'b1;
                        if (st.full)
                        begin
                            ctl.fin_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.count_inc = 1'b1;
                            if (st.cmd == CMD_ADD_FRONT)
                            begin
                                ctl.wr_sel   = WR_FRONT;
                                ctl.head_dec = 1'b1;
                            end
                            else
                            begin
                                ctl.wr_sel = WR_BACK;
                            end
                        end
                    end
                    CMD_READ:
                    begin
                        if (st.bad_a)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_RANGE;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            state_next = S_READ_WAIT;
                        end
                    end
                    CMD_SWAP:
                    begin
                        if (st.bad_a || st.bad_b)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_RANGE;
                        end
                        else if (st.same_ab)
                        begin
                            ctl.finish = 1'b1;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            state_next = S_SWAP_B;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (st.bad_a)
                        begin
                            ctl.finish     = 1'b1;
                            ctl.fin_status = ST_RANGE;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            state_next = S_REM_GET;
                        end
                    end
                    default:
                    begin
                        ctl.finish     = 1'b1;
                        ctl.fin_status = ST_RANGE;
                    end
                endcase
            end
            S_READ_WAIT:
            begin
                ctl.finish   = 1'b1;
                ctl.fin_word = WORD_RDATA;
                state_next   = S_IDLE;
            end
            S_SWAP_B:
            begin
                // word at a arrives; fetch word at b
                ctl.hold_en = 1'b1;
                ctl.rd_en   = 1'b1;
                ctl.rd_sel  = RD_B;
                state_next  = S_SWAP_WA;
            end
            S_SWAP_WA:
            begin
                ctl.wr_sel = WR_A;
                state_next = S_SWAP_WB;
            end
            S_SWAP_WB:
            begin
                ctl.wr_sel = WR_B;
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_REM_GET:
            begin
                ctl.hold_en = 1'b1;
                if (st.next_in)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_NEXT;
                    state_next = S_REM_SHIFT;
                end
                else
                begin
                    ctl.count_dec = 1'b1;
                    ctl.finish    = 1'b1;
                    ctl.fin_word  = WORD_RDATA;
                    state_next    = S_IDLE;
                end
            end
            S_REM_SHIFT:
            begin
                // entry idx+1 moves down to idx
                ctl.wr_sel  = WR_IDX;
                ctl.idx_inc = 1'b1;
                if (st.after_in)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RD_AFTER;
                end
                else
                begin
                    ctl.count_dec = 1'b1;
                    ctl.finish    = 1'b1;
                    ctl.fin_word  = WORD_HOLD;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/indexed_word_list.sv
// Channel   Ports                         Transfer
// --------  ----------------------------  ----------------------------------
// request   start, busy, request          taken on start && !busy
// result    done, result                  one-cycle strobe, always taken
//
// Add, a failed command or a swap with itself ends in the check state; read
// adds a wait state; swap reads a and b, then writes them swapped; remove moves
// one entry per cycle through the single write port of the entry memory.
// The strobe is high in the cycle after the last busy cycle, where a new
// request may already be taken. Reset clears count, ring head and controller;
// the memory needs no clearing pass. The receiver cannot stall results.
`include "indexed_word_list_defines.svh"

module indexed_word_list #(
    parameter int DEPTH = iwl_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  iwl_pkg::req_t  request,
    output logic           done,
    output iwl_pkg::rsp_t  result
);

    import iwl_pkg::*;

    // Capacity as a count value, for the result checks at the end.
    localparam logic [IDX_W-1:0] CAP_CNT = IDX_W'(DEPTH);

    // Controller to datapath commands and datapath status back.
    ctrl_cmd_t  ctl;
    dp_status_t st;

    // Full report seen, and whether it carries a full count and no data.
    logic full_rsp;
    logic full_rsp_ok;

    // The controller sequences each request: range/full checks in the check
    // state, then memory reads, writes and the remove shift loop.
    iwl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .busy  (busy),
        .ctl   (ctl)
    );

    // The datapath keeps the list as a ring in memory: position k sits at
    // (head + k) mod DEPTH, so add front is a head decrement and add back a
    // write past the tail. Remove closes the gap by moving later entries.
    iwl_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .st      (st),
        .done    (done),
        .result  (result)
    );

    assign full_rsp    = done && (result.status == ST_FULL);
    assign full_rsp_ok = (result.count_out == CAP_CNT) && (result.word_out == '0);

    // A request never completes in the cycle right after it is taken.
    `IWL_ASSERT_NEXT(a_no_early_done, clk, rst_n, start && !busy, !done, "result strobe too early")

    // The result strobe only shows once the controller is back to idle.
    `IWL_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result strobe while busy")

    // The reported count never exceeds the capacity.
    `IWL_ASSERT_SAME(a_count_cap, clk, rst_n, done, result.count_out <= CAP_CNT, "count too high")

    // A full report means a full list and no data word.
    `IWL_ASSERT_SAME(a_full_report, clk, rst_n, full_rsp, full_rsp_ok, "bad full report")

endmodule
